[design/tqps_pkg.sv]
// ----------------------------------------------------------------------------
// tqps_pkg: shared types and codes for the two queue priority server
// Holds the request and result codes, the controller state type and the
// control and status bundles that pass between the controller and the rings.
// ----------------------------------------------------------------------------
package tqps_pkg;

   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int DATA_W      = 32;
   localparam int RUN_W       = 3;
   localparam logic [RUN_W-1:0] BURST_RESET = 3'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_NORMAL    = 2'd0,
      CMD_PUSH_PREFERRED = 2'd1,
      CMD_SERVE          = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DONE = 1'b1
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ring_stat_type;

endpackage

[design/tqps_ring.sv]
// ----------------------------------------------------------------------------
// tqps_ring: one FIFO ring on a synchronous memory
// Push writes at the tail slot, pop reads the head slot into a data register
// that holds until the next pop. Head and fill count live in flops.
// ----------------------------------------------------------------------------
module tqps_ring #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tqps_pkg::ring_ctl_type          ctl,
   input  logic [tqps_pkg::DATA_W-1:0]     push_data,
   output tqps_pkg::ring_stat_type         stat,
   output logic [tqps_pkg::DATA_W-1:0]     pop_data
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [IW-1:0] LAST_I  = IW'(QUEUE_DEPTH - 1);

   logic [tqps_pkg::DATA_W-1:0] mem [QUEUE_DEPTH];
   logic [tqps_pkg::DATA_W-1:0] rd_data_ff;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] tail_sum;
   logic [SW-1:0] tail_wrap;
   logic [IW-1:0] tail;

   // The tail is head plus count, which stays below twice the depth.
   always_comb begin
      tail_sum  = SW'(head_ff) + SW'(count_ff);
      tail_wrap = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
      tail      = tail_wrap[IW-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = (head_ff == LAST_I) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail] <= push_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == DEPTH_C);
   assign pop_data   = rd_data_ff;

endmodule

[design/two_queue_priority_server.sv]
// ----------------------------------------------------------------------------
// two_queue_priority_server: two FIFO queues with a burst-limited priority
// A normal and a preferred ring feed one server, with a programmable limit on
// preferred serves in a row while normal entries wait.
// ----------------------------------------------------------------------------
// Each request goes through IDLE and DONE: in IDLE the controller accepts it,
// picks the queue and starts the ring memory access; in DONE the read data,
// held in the ring's data register, is loaded into the output register once
// the output is free. A new request is taken in the cycle after the result
// register is loaded, so the block does not take a new request while the
// last one is in flight; a stalled result holds the controller only when a
// second result is ready behind it. Enqueues into a full queue are dropped
// and flagged. burst_limit is written through csr_wr_en and resets to three.
module two_queue_priority_server #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tqps_pkg::CMD_W-1:0]           req_command,
   input  logic signed [tqps_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tqps_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_served,
   output logic                                 rsp_from_preferred,
   output logic signed [tqps_pkg::DATA_W-1:0]   rsp_served_value,
   input  logic                                 csr_wr_en,
   input  logic [tqps_pkg::RUN_W-1:0]           csr_wr_data
);

   tqps_pkg::state_type  state_ff, state_in;
   tqps_pkg::ring_ctl_type  norm_ctl, pref_ctl;
   tqps_pkg::ring_stat_type norm_stat, pref_stat;
   logic [tqps_pkg::DATA_W-1:0] norm_data, pref_data;

   logic [tqps_pkg::RUN_W-1:0] burst_ff, run_ff, run_in;
   logic                       accept;
   logic                       out_free;
   logic                       load_rsp;

   // Result fields decided at accept, held until the read data returns.
   tqps_pkg::status_type pend_status_ff, pend_status_in;
   logic                 pend_served_ff, pend_served_in;
   logic                 pend_pref_ff, pend_pref_in;

   logic                              rsp_valid_ff;
   tqps_pkg::status_type              rsp_status_ff;
   logic                              rsp_served_ff;
   logic                              rsp_pref_ff;
   logic [tqps_pkg::DATA_W-1:0]       rsp_value_ff;
   logic [tqps_pkg::DATA_W-1:0]       value_sel;

   tqps_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_norm_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (norm_ctl),
      .push_data (req_value),
      .stat      (norm_stat),
      .pop_data  (norm_data)
   );

   tqps_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pref_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pref_ctl),
      .push_data (req_value),
      .stat      (pref_stat),
      .pop_data  (pref_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tqps_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tqps_pkg::ST_DONE;
            end
         end
         tqps_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tqps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tqps_pkg::ST_IDLE;
         end
      endcase
   end

   // Controller outputs.
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = 1'b1;
      load_rsp  = 1'b0;
      case (state_ff)
         tqps_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         tqps_pkg::ST_DONE: begin
            load_rsp = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      accept = req_valid && !req_stall;
   end

   // Queue selection and burst accounting for the accepted request.
   always_comb begin
      norm_ctl       = '0;
      pref_ctl       = '0;
      run_in         = run_ff;
      pend_status_in = pend_status_ff;
      pend_served_in = pend_served_ff;
      pend_pref_in   = pend_pref_ff;
      if (accept) begin
         pend_status_in = tqps_pkg::STATUS_OK;
         pend_served_in = 1'b0;
         pend_pref_in   = 1'b0;
         case (req_command)
            tqps_pkg::CMD_PUSH_NORMAL: begin
               if (norm_stat.full) begin
                  pend_status_in = tqps_pkg::STATUS_FULL;
               end else begin
                  norm_ctl.push = 1'b1;
               end
            end
            tqps_pkg::CMD_PUSH_PREFERRED: begin
               if (pref_stat.full) begin
                  pend_status_in = tqps_pkg::STATUS_FULL;
               end else begin
                  pref_ctl.push = 1'b1;
               end
            end
            tqps_pkg::CMD_SERVE: begin
               // Preferred wins below the limit, or when nothing normal waits.
               if (!pref_stat.empty && (run_ff < burst_ff || norm_stat.empty)) begin
                  pref_ctl.pop   = 1'b1;
                  pend_served_in = 1'b1;
                  pend_pref_in   = 1'b1;
                  if (!norm_stat.empty) begin
                     run_in = run_ff + 1'b1;
                  end
               end else if (!norm_stat.empty) begin
                  norm_ctl.pop   = 1'b1;
                  pend_served_in = 1'b1;
                  run_in         = '0;
               end else begin
                  pend_status_in = tqps_pkg::STATUS_EMPTY;
               end
            end
            default: begin
               pend_status_in = tqps_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_comb begin
      value_sel = '0;
      if (pend_served_ff) begin
         value_sel = pend_pref_ff ? pref_data : norm_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tqps_pkg::ST_IDLE;
         burst_ff     <= tqps_pkg::BURST_RESET;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         if (csr_wr_en) begin
            burst_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_served_ff <= pend_served_in;
      pend_pref_ff   <= pend_pref_in;
      if (load_rsp) begin
         rsp_status_ff <= pend_status_ff;
         rsp_served_ff <= pend_served_ff;
         rsp_pref_ff   <= pend_pref_ff;
         rsp_value_ff  <= value_sel;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_served         = rsp_served_ff;
   assign rsp_from_preferred = rsp_pref_ff;
   assign rsp_served_value   = rsp_value_ff;

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !((norm_ctl.pop && norm_stat.empty) || (pref_ctl.pop && pref_stat.empty)))
      else $error("pop issued to an empty ring");

   a_accept_to_done: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == tqps_pkg::ST_DONE))
      else $error("accepted request did not move the controller to DONE");

   a_served_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_served_ff) |-> (rsp_status_ff == tqps_pkg::STATUS_OK))
      else $error("served result carries a failing status");

   a_run_moves_on_serve: assert property (@(posedge clock) disable iff (reset)
      !$stable(run_ff) |-> ($past(reset) || $past(norm_ctl.pop || pref_ctl.pop)))
      else $error("run counter changed without a serve");

endmodule
